>>> src/swat_pkg.sv
// Shared types, constants and window arithmetic for the ack tracker.
package swat_pkg;

  localparam int FRAME_W   = 48;
  localparam int WIN_W     = 7;
  localparam int SLOT_IN_W = 10;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SS_THRESH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_WIN  = 2'd2;

  // Register reset values
  localparam logic [WIN_W-1:0] SS_THRESH_RST = 7'd32;
  localparam logic [WIN_W-1:0] WIN_LIMIT_RST = 7'd64;
  localparam logic [WIN_W-1:0] INIT_WIN_RST  = 7'd16;

  // Window operation requested by the sequencer
  typedef struct packed {
    logic grow;
    logic shrink;
  } win_cmd_t;

  // Limit register clamped to [1, max_win]
  function automatic logic [WIN_W-1:0] eff_limit(input logic [WIN_W-1:0] lim,
                                                 input logic [WIN_W-1:0] max_win);
    logic [WIN_W-1:0] r;
    r = lim;
    if (r == '0) r = 7'd1;
    if (r > max_win) r = max_win;
    return r;
  endfunction

  // Window candidate (one bit of headroom) clamped to [1, lim]
  function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W:0]   w,
                                                 input logic [WIN_W-1:0] lim);
    logic [WIN_W-1:0] r;
    if (w > {1'b0, lim}) r = lim;
    else                 r = w[WIN_W-1:0];
    if (r == '0) r = 7'd1;
    return r;
  endfunction

endpackage

>>> src/sliding_window_ack_tracker_top.sv
// Top level: selective-repeat sender window with AIMD congestion control.
//
//  channel   | ports                                            | handshake
//  ----------+--------------------------------------------------+-------------------------
//  command   | action, ack_index, end_known, end_frame          | start & !busy
//  result    | base_frame, window_size, all_acked               | valid, one cycle, no stall
//  config    | cfg_addr, cfg_wdata                              | cfg_wr_en, no wait
//
//  Sequencing: a timeout or an ack of a non-base slot goes from idle straight
//  to the result strobe. An ack of the base slot enters the check state; each
//  slide step clears the passed slot in check and waits for the next mark in
//  the wait state, and the slide stops at an unmarked slot or at the end frame
//  (it slides at most RING_DEPTH slots). busy holds through the strobe cycle,
//  so the next transaction is taken in the cycle after it. Each slide step is
//  a check/clear state plus one mark memory read, so the mark RAM read latency
//  sets the step rate.
//  After reset a clearing pass sweeps every slot of the mark RAM;
//  busy is high throughout and no transaction is taken. Config writes are
//  taken at any time. The receiver cannot stall: each result shows for one
//  cycle under valid. RING_DEPTH must be a power of two.
module sliding_window_ack_tracker_top #(
  parameter int RING_DEPTH = 1024,
  parameter int MAX_WINDOW = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // command transaction
  input  logic                                start,
  output logic                                busy,
  input  logic                                action,
  input  logic [swat_pkg::SLOT_IN_W-1:0]      ack_index,
  input  logic                                end_known,
  input  logic [swat_pkg::FRAME_W-1:0]        end_frame,
  // result transaction
  output logic                                valid,
  output logic [swat_pkg::FRAME_W-1:0]        base_frame,
  output logic [swat_pkg::WIN_W-1:0]          window_size,
  output logic                                all_acked,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [swat_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [swat_pkg::WIN_W-1:0]          cfg_wdata
);
  import swat_pkg::*;

  localparam int RAW = $clog2(RING_DEPTH);
  localparam int XW  = (RAW > SLOT_IN_W) ? RAW : SLOT_IN_W;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;  // post-reset sweep of the mark RAM
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;  // base slot known marked
  localparam logic [2:0] S_WAIT  = 3'd3;  // mark of new base slot arriving
  localparam logic [2:0] S_DONE  = 3'd4;  // result strobe

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [RAW-1:0]     clr_cnt;
  logic [FRAME_W-1:0] base;
  logic [FRAME_W-1:0] base_inc;
  logic               end_known_q;
  logic [FRAME_W-1:0] end_frame_q;
  logic               acked_q;

  logic [XW-1:0]      slot_ext;
  logic [RAW-1:0]     slot;
  logic [RAW-1:0]     base_slot;
  logic               end_hit;

  logic               ram_we;
  logic [RAW-1:0]     ram_waddr;
  logic               ram_wdata;
  logic [RAW-1:0]     ram_raddr;
  logic               ram_rdata;

  win_cmd_t           win_cmd;

  assign slot_ext  = XW'(ack_index);
  assign slot      = slot_ext[RAW-1:0];
  assign base_slot = base[RAW-1:0];
  // the shared wide unit: one increment and one equality per step
  assign base_inc  = base + 48'd1;
  assign end_hit   = end_known_q && (end_frame_q == base);

  // Sequencer and RAM port steering
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = base_slot;
    ram_wdata  = 1'b0;
    ram_raddr  = base_inc[RAW-1:0];
    win_cmd    = '0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        if (clr_cnt == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (action) begin
            win_cmd.shrink = 1'b1;
            state_next     = S_DONE;
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = slot;
            ram_wdata  = 1'b1;
            state_next = (slot == base_slot) ? S_CHECK : S_DONE;
          end
        end
      end
      S_CHECK: begin
        if (end_hit) begin
          win_cmd.grow = 1'b1;
          state_next   = S_DONE;
        end else begin
          ram_we     = 1'b1;   // clear passed slot, fetch the next one
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (ram_rdata) begin
          state_next = S_CHECK;
        end else begin
          win_cmd.grow = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      base    <= '0;
      acked_q <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == S_IDLE && start) acked_q <= 1'b0;
      if (state == S_CHECK) begin
        if (end_hit) acked_q <= 1'b1;
        else         base    <= base_inc;
      end
    end
  end

  // command payload held for the slide
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      end_known_q <= end_known;
      end_frame_q <= end_frame;
    end
  end

  swat_mark_ram #(
    .DEPTH (RING_DEPTH),
    .AW    (RAW)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swat_win_unit #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_win (
    .clk       (clk),
    .rst       (rst),
    .cmd       (win_cmd),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .window    (window_size)
  );

  assign busy       = (state != S_IDLE);
  assign valid      = (state == S_DONE);
  assign base_frame = base;
  assign all_acked  = acked_q;

endmodule

>>> src/swat_mark_ram.sv
// Single-bit mark memory: one write port, one registered read port.
module swat_mark_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/swat_win_unit.sv
// Congestion window register, its configuration and the grow/shrink unit.
module swat_win_unit #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  swat_pkg::win_cmd_t                cmd,
  input  logic                              cfg_wr_en,
  input  logic [swat_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [swat_pkg::WIN_W-1:0]        cfg_wdata,
  output logic [swat_pkg::WIN_W-1:0]        window
);
  import swat_pkg::*;

  localparam logic [WIN_W-1:0] MAX_W = WIN_W'(MAX_WINDOW);
  localparam logic [WIN_W-1:0] WIN_RST =
    clamp_win({1'b0, INIT_WIN_RST}, eff_limit(WIN_LIMIT_RST, MAX_W));

  logic [WIN_W-1:0] ss_thresh;
  logic [WIN_W-1:0] win_limit;
  logic [WIN_W-1:0] lim;
  logic [WIN_W:0]   cand;
  logic [WIN_W-1:0] window_next;

  assign lim = eff_limit(win_limit, MAX_W);

  always_comb begin
    cand = {1'b0, window};
    if (cmd.shrink) begin
      cand = {2'b00, window[WIN_W-1:1]};
    end else if (window < ss_thresh) begin
      cand = {window, 1'b0};
      if (cand > {1'b0, ss_thresh}) cand = {1'b0, ss_thresh};
    end else begin
      cand = {1'b0, window} + 8'd1;
    end
    window_next = clamp_win(cand, lim);
  end

  // the initial window value only matters at the moment it is written
  always_ff @(posedge clk) begin
    if (rst) begin
      ss_thresh <= SS_THRESH_RST;
      win_limit <= WIN_LIMIT_RST;
      window    <= WIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SS_THRESH: ss_thresh <= cfg_wdata;
        REG_WIN_LIMIT: win_limit <= cfg_wdata;
        REG_INIT_WIN: begin
          window <= clamp_win({1'b0, cfg_wdata}, lim);
        end
        default: ;
      endcase
    end else if (cmd.grow || cmd.shrink) begin
      window <= window_next;
    end
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the selective-repeat ack tracker and its AIMD window.
module testbench;
  import swat_pkg::*;

  localparam int RING          = 1024;
  localparam int WIN_MAX       = 64;
  localparam int CYCLE_LIMIT   = 600000;  // several times the slowest legal run
  localparam int SETTLE_CYCLES = 40;      // watch for stray strobes after the drain

  localparam logic ACT_ACK     = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [FRAME_W-1:0] base;
    logic [WIN_W-1:0]   win;
    logic               done;
  } window_report_t;

  // DUT-facing signals; the inputs are known from time zero
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  logic                 action    = ACT_ACK;
  logic [SLOT_IN_W-1:0] ack_index = '0;
  logic                 end_known = 1'b0;
  logic [FRAME_W-1:0]   end_frame = '0;
  logic                 valid;
  logic [FRAME_W-1:0]   base_frame;
  logic [WIN_W-1:0]     window_size;
  logic                 all_acked;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = '0;
  logic [WIN_W-1:0]     cfg_wdata = '0;

  // Predictor state: marks ring, base number, window and register copies
  bit                 acked_slot [RING];
  logic [FRAME_W-1:0] base_no   = '0;
  int                 cwnd;
  int                 ss_thresh = int'(SS_THRESH_RST);
  int                 win_limit = int'(WIN_LIMIT_RST);
  int                 init_win  = int'(INIT_WIN_RST);

  window_report_t pending_reports[$];
  int             mismatch_count = 0;
  int             cycle_count;

  sliding_window_ack_tracker_top #(
    .RING_DEPTH (RING),
    .MAX_WINDOW (WIN_MAX)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .ack_index   (ack_index),
    .end_known   (end_known),
    .end_frame   (end_frame),
    .valid       (valid),
    .base_frame  (base_frame),
    .window_size (window_size),
    .all_acked   (all_acked),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Window arithmetic of the predictor
  // ---------------------------------------------------------------------------

  // Limit register pulled into [1, WIN_MAX]
  function automatic int limit_now();
    int l;
    l = win_limit;
    if (l < 1) l = 1;
    if (l > WIN_MAX) l = WIN_MAX;
    return l;
  endfunction

  // Any new window value lands in [1, limit]
  function automatic int fit_window(input int w);
    int r;
    r = w;
    if (r > limit_now()) r = limit_now();
    if (r < 1) r = 1;
    return r;
  endfunction

  // Works out the outcome of one accepted transaction and queues it
  function automatic void predict_window_update(input logic act,
                                                input logic [SLOT_IN_W-1:0] slot,
                                                input logic ek,
                                                input logic [FRAME_W-1:0] ef);
    window_report_t r;
    int w;
    int steps;
    r.done = 1'b0;
    if (act == ACT_TIMEOUT) begin
      cwnd = fit_window(cwnd / 2);
    end else if (slot == base_no[SLOT_IN_W-1:0]) begin
      acked_slot[slot] = 1'b1;
      // slide over marked slots; at most one lap since each pass clears
      for (steps = 0; steps <= RING; steps++) begin
        if (!acked_slot[base_no[SLOT_IN_W-1:0]]) break;
        if (ek && ef == base_no) begin
          r.done = 1'b1;  // end slot keeps its mark
          break;
        end
        acked_slot[base_no[SLOT_IN_W-1:0]] = 1'b0;
        base_no = base_no + 1'b1;
      end
      // slow start below the threshold, additive above it
      if (cwnd < ss_thresh) begin
        w = cwnd * 2;
        if (w > ss_thresh) w = ss_thresh;
      end else begin
        w = cwnd + 1;
      end
      cwnd = fit_window(w);
    end else begin
      acked_slot[slot] = 1'b1;
    end
    r.base = base_no;
    r.win  = cwnd[WIN_W-1:0];
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Presents one command and holds it until the transaction is taken.
  // start is left high so back-to-back commands need no second assignment.
  task automatic send_item(input logic act, input logic [SLOT_IN_W-1:0] idx,
                           input logic ek, input logic [FRAME_W-1:0] ef);
    start     <= 1'b1;
    action    <= act;
    ack_index <= idx;
    end_known <= ek;
    end_frame <= ef;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_window_update(act, idx, ek, ef);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sender quiet until every queued result has been seen
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_SS_THRESH: ss_thresh = int'(val);
      REG_WIN_LIMIT: win_limit = int'(val);
      REG_INIT_WIN: begin
        init_win = int'(val);
        cwnd     = fit_window(int'(val));  // write restarts the window
      end
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [WIN_W-1:0] th, input logic [WIN_W-1:0] lim,
                               input logic [WIN_W-1:0] iw);
    drain();
    write_reg(REG_SS_THRESH, th);
    write_reg(REG_WIN_LIMIT, lim);
    write_reg(REG_INIT_WIN, iw);
  endtask

  function automatic logic [FRAME_W-1:0] rand_frame();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[FRAME_W-1:0];
  endfunction

  // Mostly in-window acks with the base acked often enough to keep it moving;
  // a share of timeouts and acks scattered over the whole ring.
  task automatic send_random_item();
    int                   pick;
    int                   span;
    logic                 act;
    logic [SLOT_IN_W-1:0] idx;
    logic                 ek;
    logic [FRAME_W-1:0]   ef;
    pick = $urandom_range(99);
    span = (cwnd > 1) ? cwnd : 2;
    act  = (pick < 8) ? ACT_TIMEOUT : ACT_ACK;
    if (pick < 38)      idx = base_no[SLOT_IN_W-1:0];
    else if (pick < 85) idx = base_no[SLOT_IN_W-1:0] + SLOT_IN_W'($urandom_range(1, span));
    else                idx = SLOT_IN_W'($urandom());
    ek = 1'b0;
    ef = rand_frame();
    if ($urandom_range(99) < 35) begin
      ek = 1'b1;
      ef = base_no + FRAME_W'($urandom_range(0, 6));  // end frame close ahead
    end else if ($urandom_range(99) < 25) begin
      ek = 1'b1;
    end
    send_item(act, idx, ek, ef);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: halve down to the floor of one; odd fields at their extremes
  task automatic test_timeout_floor();
    send_item(ACT_TIMEOUT, 10'd1023, 1'b1, '1);
    send_item(ACT_TIMEOUT, 10'd0, 1'b0, '0);
    send_item(ACT_TIMEOUT, 10'd512, 1'b1, 48'h0);
    send_item(ACT_TIMEOUT, 10'd0, 1'b0, '1);
    send_item(ACT_TIMEOUT, 10'd1023, 1'b1, 48'h8000_0000_0000);  // stays at one
  endtask

  // Out-of-order marks, slide, completion at the end frame and its repeat
  task automatic test_slide_and_completion();
    send_item(ACT_ACK, 10'd1023, 1'b0, '0);  // far slot, mark only
    send_item(ACT_ACK, 10'd2, 1'b0, '0);
    send_item(ACT_ACK, 10'd1, 1'b1, '1);
    send_item(ACT_ACK, 10'd0, 1'b1, '1);     // slides 0..2, end not reached
    send_item(ACT_ACK, 10'd4, 1'b0, '0);
    send_item(ACT_ACK, 10'd5, 1'b0, '0);
    send_item(ACT_ACK, 10'd3, 1'b1, 48'd5);  // stops at frame 5, complete
    send_item(ACT_ACK, 10'd5, 1'b1, 48'd5);  // complete again, grows again
    send_item(ACT_ACK, 10'd5, 1'b0, 48'd5);  // end unknown: moves on
    send_item(ACT_ACK, 10'd6, 1'b1, 48'd0);  // doubling reaches the threshold
    send_item(ACT_ACK, 10'd7, 1'b0, '0);     // additive step
    send_item(ACT_ACK, 10'd9, 1'b0, '0);     // ahead of base, window untouched
  endtask

  // Threshold zero, limit outside its range, initial window clamped both ways
  task automatic test_window_extremes();
    load_settings(7'd0, 7'd127, 7'd127);
    send_item(ACT_TIMEOUT, 10'd0, 1'b0, '0);
    send_item(ACT_ACK, base_no[SLOT_IN_W-1:0], 1'b0, '0);
    drain();
    write_reg(REG_WIN_LIMIT, 7'd0);                        // window not reclamped yet
    send_item(ACT_ACK, base_no[SLOT_IN_W-1:0], 1'b0, '0);  // growth hits limit of one
    load_settings(7'd127, 7'd64, 7'd0);
    send_item(ACT_ACK, base_no[SLOT_IN_W-1:0], 1'b0, '0);
  endtask

  // Mark every slot but the base, then ack the base: the slide makes one full lap
  task automatic test_full_ring();
    logic [SLOT_IN_W-1:0] b;
    logic [SLOT_IN_W-1:0] stride;
    int                   k;
    b      = base_no[SLOT_IN_W-1:0];
    stride = SLOT_IN_W'($urandom_range(0, 511) * 2 + 1);  // odd: visits every slot
    for (k = 1; k < RING; k++) begin
      send_item(ACT_ACK, b + SLOT_IN_W'(k) * stride, 1'($urandom_range(1)), rand_frame());
    end
    send_item(ACT_ACK, b, 1'b0, rand_frame());
  endtask

  // idle_pct is the chance, each free cycle, that the sender stays quiet
  task automatic test_random_traffic(input logic [WIN_W-1:0] th, input logic [WIN_W-1:0] lim,
                                     input logic [WIN_W-1:0] iw, input int idle_pct,
                                     input int count);
    load_settings(th, lim, iw);
    repeat (count) begin
      while ($urandom_range(99) < idle_pct) hold_off(1);
      send_random_item();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each strobed result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    window_report_t exp_r;
    if (!rst && valid) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: base_frame %0h window_size %0d all_acked %0b",
               base_frame, window_size, all_acked);
        mismatch_count++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (base_frame !== exp_r.base) begin
          $error("base_frame: expected %0h, actual %0h", exp_r.base, base_frame);
          mismatch_count++;
        end
        if (window_size !== exp_r.win) begin
          $error("window_size: expected %0d, actual %0d", exp_r.win, window_size);
          mismatch_count++;
        end
        if (all_acked !== exp_r.done) begin
          $error("all_acked: expected %0b, actual %0b", exp_r.done, all_acked);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog; the clearing pass after reset is well inside the limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    cwnd = fit_window(init_win);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_timeout_floor();
    test_slide_and_completion();
    test_window_extremes();
    test_full_ring();

    // phases: back to back, sparse sender, dense again, light idling, sparse again, light idling
    test_random_traffic(7'd32, 7'd64, 7'd16, 0, 18);
    test_random_traffic(7'd0, 7'd127, 7'd127, 87, 18);
    test_random_traffic(7'd127, 7'd1, 7'd0, 0, 18);
    test_random_traffic(7'd1, 7'd0, 7'd64, 19, 18);
    test_random_traffic(7'd64, 7'd64, 7'd1, 87, 18);
    test_random_traffic(WIN_W'($urandom_range(127)), WIN_W'($urandom_range(127)),
                        WIN_W'($urandom_range(127)), 19, 18);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
